// ===== design/lwf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwf_pkg
// Shared types and constants of the lookahead waypoint follower: register
// indexes, controller states, datapath commands and fixed-point constants.
// ----------------------------------------------------------------------------
package lwf_pkg;

	localparam int MAX_WAYPOINTS_DEF = 16;

	localparam int CFG_W      = 31;
	localparam int REG_IDX_W  = 3;
	localparam int COUNT_W    = 5;
	localparam int SLOT_W     = 4;
	localparam int IDX_PORT_W = 4;
	localparam int COORD_W    = 32;
	localparam int QUAT_W     = 16;
	localparam int CNT_W      = 6;
	localparam int JOB_W      = 3;

	localparam int SQ_STEPS    = 4;
	localparam int SQRT_STEPS  = 34;
	localparam int DIV_STEPS   = 32;
	localparam int SCALE_JOBS  = 6;
	localparam int QUAT_JOBS   = 2;
	localparam int AXES        = 3;
	localparam int QUAT_FRAC   = 27;

	localparam logic [CFG_W-1:0]   ACCEPT_RESET    = 31'd32768;
	localparam logic [CFG_W-1:0]   LOOKAHEAD_RESET = 31'd98304;
	localparam logic [CFG_W-1:0]   CRUISE_RESET    = 31'd65536;
	localparam logic               HOLD_RESET      = 1'b1;
	localparam logic [COUNT_W-1:0] COUNT_RESET     = 5'd1;
	localparam logic [QUAT_W-1:0]  Q_ONE           = 16'd16384;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ACCEPT_RADIUS = 3'd0,
		REG_LOOKAHEAD     = 3'd1,
		REG_CRUISE_SPEED  = 3'd2,
		REG_HOLD_AT_END   = 3'd3,
		REG_WAYPOINT_CNT  = 3'd4
	} reg_idx_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_STORE_WP,
		CMD_TAKE_POS,
		CMD_CLAMP,
		CMD_DIFF,
		CMD_SQ_D,
		CMD_SQ_AB,
		CMD_RT_ACC,
		CMD_RT_QUO,
		CMD_RT_STEP,
		CMD_CHECK,
		CMD_ZERO,
		CMD_SMUL,
		CMD_SDLOAD,
		CMD_DIV_STEP,
		CMD_SSTORE,
		CMD_AB,
		CMD_RSTORE,
		CMD_QDEFAULT,
		CMD_QDLOAD,
		CMD_QSTORE,
		CMD_EMIT
	} cmd_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_DIFF,
		ST_SQ_D,
		ST_RTLD_D,
		ST_RT_D,
		ST_CHECK,
		ST_ZERO,
		ST_SMUL,
		ST_SDLOAD,
		ST_SDIV,
		ST_SSTORE,
		ST_AB,
		ST_SQ_AB,
		ST_RTLD_AB,
		ST_RT_AB,
		ST_RSTORE,
		ST_QDEF,
		ST_QDLOAD,
		ST_QDIV,
		ST_QRTLD,
		ST_QRT,
		ST_QSTORE,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		cmd_op_t          op;
		logic [CNT_W-1:0] cnt;
		logic [JOB_W-1:0] job;
	} cmd_t;

	typedef struct packed {
		logic drop;
		logic root_zero;
	} status_t;

	function automatic logic [31:0] mag33(input logic signed [32:0] v);
		logic signed [32:0] n;
		n = -v;
		return v[32] ? n[31:0] : v[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/lwf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwf_ctrl
// Sequencer of the follower: walks one tick through distance, scaling and
// heading steps, one datapath command per cycle, stalling on a full output.
// ----------------------------------------------------------------------------
module lwf_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             operation,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire lwf_pkg::status_t status,
	output lwf_pkg::cmd_t         cmd
);

	lwf_pkg::ctrl_state_t state_q, state_d;
	logic [lwf_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic [lwf_pkg::JOB_W-1:0] job_q, job_d;
	logic out_valid_q;
	logic emit;
	logic cnt_sq_last, cnt_rt_last, cnt_div_last;

	assign cnt_sq_last  = (cnt_q == lwf_pkg::CNT_W'(lwf_pkg::SQ_STEPS - 1));
	assign cnt_rt_last  = (cnt_q == lwf_pkg::CNT_W'(lwf_pkg::SQRT_STEPS - 1));
	assign cnt_div_last = (cnt_q == lwf_pkg::CNT_W'(lwf_pkg::DIV_STEPS - 1));
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lwf_pkg::ST_IDLE;
			cnt_q       <= '0;
			job_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			job_q   <= job_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = '0;
		job_d    = job_q;
		cmd.op   = lwf_pkg::CMD_NONE;
		cmd.cnt  = cnt_q;
		cmd.job  = job_q;
		in_ready = 1'b0;
		emit     = 1'b0;
		unique case (state_q)
			lwf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (operation) begin
						cmd.op  = lwf_pkg::CMD_TAKE_POS;
						state_d = lwf_pkg::ST_CLAMP;
					end else begin
						cmd.op = lwf_pkg::CMD_STORE_WP;
					end
				end
			end
			lwf_pkg::ST_CLAMP: begin
				cmd.op  = lwf_pkg::CMD_CLAMP;
				state_d = lwf_pkg::ST_DIFF;
			end
			lwf_pkg::ST_DIFF: begin
				cmd.op  = lwf_pkg::CMD_DIFF;
				state_d = lwf_pkg::ST_SQ_D;
			end
			lwf_pkg::ST_SQ_D: begin
				cmd.op = lwf_pkg::CMD_SQ_D;
				if (cnt_sq_last) state_d = lwf_pkg::ST_RTLD_D;
				else cnt_d = cnt_q + 1'b1;
			end
			lwf_pkg::ST_RTLD_D: begin
				cmd.op  = lwf_pkg::CMD_RT_ACC;
				state_d = lwf_pkg::ST_RT_D;
			end
			lwf_pkg::ST_RT_D: begin
				cmd.op = lwf_pkg::CMD_RT_STEP;
				if (cnt_rt_last) state_d = lwf_pkg::ST_CHECK;
				else cnt_d = cnt_q + 1'b1;
			end
			lwf_pkg::ST_CHECK: begin
				cmd.op = lwf_pkg::CMD_CHECK;
				job_d  = '0;
				if (status.drop) state_d = lwf_pkg::ST_IDLE;
				else if (status.root_zero) state_d = lwf_pkg::ST_ZERO;
				else state_d = lwf_pkg::ST_SMUL;
			end
			lwf_pkg::ST_ZERO: begin
				cmd.op  = lwf_pkg::CMD_ZERO;
				state_d = lwf_pkg::ST_AB;
			end
			lwf_pkg::ST_SMUL: begin
				cmd.op  = lwf_pkg::CMD_SMUL;
				state_d = lwf_pkg::ST_SDLOAD;
			end
			lwf_pkg::ST_SDLOAD: begin
				cmd.op  = lwf_pkg::CMD_SDLOAD;
				state_d = lwf_pkg::ST_SDIV;
			end
			lwf_pkg::ST_SDIV: begin
				cmd.op = lwf_pkg::CMD_DIV_STEP;
				if (cnt_div_last) state_d = lwf_pkg::ST_SSTORE;
				else cnt_d = cnt_q + 1'b1;
			end
			lwf_pkg::ST_SSTORE: begin
				cmd.op = lwf_pkg::CMD_SSTORE;
				if (job_q == lwf_pkg::JOB_W'(lwf_pkg::SCALE_JOBS - 1)) begin
					state_d = lwf_pkg::ST_AB;
				end else begin
					job_d   = job_q + 1'b1;
					state_d = lwf_pkg::ST_SMUL;
				end
			end
			lwf_pkg::ST_AB: begin
				cmd.op  = lwf_pkg::CMD_AB;
				state_d = lwf_pkg::ST_SQ_AB;
			end
			lwf_pkg::ST_SQ_AB: begin
				cmd.op = lwf_pkg::CMD_SQ_AB;
				if (cnt_sq_last) state_d = lwf_pkg::ST_RTLD_AB;
				else cnt_d = cnt_q + 1'b1;
			end
			lwf_pkg::ST_RTLD_AB: begin
				cmd.op  = lwf_pkg::CMD_RT_ACC;
				state_d = lwf_pkg::ST_RT_AB;
			end
			lwf_pkg::ST_RT_AB: begin
				cmd.op = lwf_pkg::CMD_RT_STEP;
				if (cnt_rt_last) state_d = lwf_pkg::ST_RSTORE;
				else cnt_d = cnt_q + 1'b1;
			end
			lwf_pkg::ST_RSTORE: begin
				cmd.op = lwf_pkg::CMD_RSTORE;
				job_d  = '0;
				if (status.root_zero) state_d = lwf_pkg::ST_QDEF;
				else state_d = lwf_pkg::ST_QDLOAD;
			end
			lwf_pkg::ST_QDEF: begin
				cmd.op  = lwf_pkg::CMD_QDEFAULT;
				state_d = lwf_pkg::ST_EMIT;
			end
			lwf_pkg::ST_QDLOAD: begin
				cmd.op  = lwf_pkg::CMD_QDLOAD;
				state_d = lwf_pkg::ST_QDIV;
			end
			lwf_pkg::ST_QDIV: begin
				cmd.op = lwf_pkg::CMD_DIV_STEP;
				if (cnt_div_last) state_d = lwf_pkg::ST_QRTLD;
				else cnt_d = cnt_q + 1'b1;
			end
			lwf_pkg::ST_QRTLD: begin
				cmd.op  = lwf_pkg::CMD_RT_QUO;
				state_d = lwf_pkg::ST_QRT;
			end
			lwf_pkg::ST_QRT: begin
				cmd.op = lwf_pkg::CMD_RT_STEP;
				if (cnt_rt_last) state_d = lwf_pkg::ST_QSTORE;
				else cnt_d = cnt_q + 1'b1;
			end
			lwf_pkg::ST_QSTORE: begin
				cmd.op = lwf_pkg::CMD_QSTORE;
				if (job_q == lwf_pkg::JOB_W'(lwf_pkg::QUAT_JOBS - 1)) begin
					state_d = lwf_pkg::ST_EMIT;
				end else begin
					job_d   = job_q + 1'b1;
					state_d = lwf_pkg::ST_QDLOAD;
				end
			end
			lwf_pkg::ST_EMIT: begin
				// wait for the output register to drain
				if (!out_valid_q || out_ready) begin
					cmd.op  = lwf_pkg::CMD_EMIT;
					emit    = 1'b1;
					state_d = lwf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lwf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== design/lwf_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lwf_dpath
// Datapath of the follower: waypoint table, configuration registers, one
// shared multiplier, a bit-serial square root and a bit-serial divider.
// ----------------------------------------------------------------------------
module lwf_dpath #(
	parameter int MAX_WAYPOINTS = lwf_pkg::MAX_WAYPOINTS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write,
	input  wire logic [lwf_pkg::REG_IDX_W-1:0]        cfg_index,
	input  wire logic [lwf_pkg::CFG_W-1:0]            cfg_data,
	input  wire logic [lwf_pkg::SLOT_W-1:0]           slot,
	input  wire logic signed [lwf_pkg::COORD_W-1:0]   coord_x,
	input  wire logic signed [lwf_pkg::COORD_W-1:0]   coord_y,
	input  wire logic signed [lwf_pkg::COORD_W-1:0]   coord_z,
	input  wire lwf_pkg::cmd_t                        cmd,
	output lwf_pkg::status_t                          status,
	output logic signed [lwf_pkg::COORD_W-1:0]        setpoint_x,
	output logic signed [lwf_pkg::COORD_W-1:0]        setpoint_y,
	output logic signed [lwf_pkg::COORD_W-1:0]        setpoint_z,
	output logic signed [lwf_pkg::COORD_W-1:0]        velocity_x,
	output logic signed [lwf_pkg::COORD_W-1:0]        velocity_y,
	output logic signed [lwf_pkg::COORD_W-1:0]        velocity_z,
	output logic signed [lwf_pkg::QUAT_W-1:0]         quat_w,
	output logic signed [lwf_pkg::QUAT_W-1:0]         quat_z,
	output logic [lwf_pkg::IDX_PORT_W-1:0]            target_index
);

	localparam int IW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
	localparam int NW = (IW + 1 > lwf_pkg::COUNT_W) ? IW + 1 : lwf_pkg::COUNT_W;

	logic [31:0] mem_x [MAX_WAYPOINTS];
	logic [31:0] mem_y [MAX_WAYPOINTS];
	logic [31:0] mem_z [MAX_WAYPOINTS];

	logic [lwf_pkg::CFG_W-1:0]   accept_q, look_q, cruise_q;
	logic                        hold_q;
	logic [lwf_pkg::COUNT_W-1:0] count_q;
	logic [IW-1:0]               idx_q;

	logic signed [31:0] px_q, py_q, pz_q, wx_q, wy_q, wz_q;
	logic signed [32:0] dx_q, dy_q, dz_q, a_q, b_q;
	logic [63:0]        mul_q;
	logic [65:0]        acc_q;
	logic [67:0]        rad_q;
	logic [33:0]        root_q;
	logic [36:0]        srem_q;
	logic [32:0]        rem_q, den_q, dist_q, r_q;
	logic [31:0]        numlo_q, quo_q;
	logic [30:0]        step_q;
	logic signed [33:0] sx_q, sy_q, sz_q;
	logic [31:0]        vx_q, vy_q, vz_q;
	logic [15:0]        qw_q, qz_q;
	logic [31:0]        osx_q, osy_q, osz_q, ovx_q, ovy_q, ovz_q;
	logic [15:0]        oqw_q, oqz_q;
	logic [lwf_pkg::IDX_PORT_W-1:0] oidx_q;

	logic [NW-1:0]      n_cnt, n_max, n_lim, n_eff;
	logic [IW-1:0]      clamp_idx, next_idx, rd_addr, wr_addr;
	logic               slot_ok, near, adv;
	logic signed [32:0] sq_sel, d_job;
	logic [31:0]        mul_a, mul_b, k_job;
	logic [36:0]        t_rem, trial;
	logic               take;
	logic [33:0]        shifted;
	logic               dtake;
	logic [63:0]        snum, qnum;
	logic signed [34:0] qsum;
	logic signed [33:0] q34, sd;
	logic [15:0]        rnd, rnd_neg;

	// target count limits: zero acts as one, capped by table depth
	assign n_cnt     = NW'(count_q);
	assign n_max     = NW'(MAX_WAYPOINTS);
	assign n_lim     = (n_cnt > n_max) ? n_max : n_cnt;
	assign n_eff     = (n_lim == '0) ? NW'(1) : n_lim;
	assign clamp_idx = (NW'(idx_q) >= n_eff) ? IW'(n_eff - NW'(1)) : idx_q;
	assign near      = (root_q < 34'(accept_q));
	assign adv       = near && ((NW'(idx_q) + NW'(1)) < n_eff);
	assign next_idx  = adv ? idx_q + IW'(1) : idx_q;
	assign rd_addr   = (cmd.op == lwf_pkg::CMD_CLAMP) ? clamp_idx : next_idx;
	assign slot_ok   = (NW'(slot) < n_max);
	assign wr_addr   = IW'(slot);

	assign status.drop      = near && !adv && !hold_q;
	assign status.root_zero = (root_q == '0);

	always_comb begin
		unique case (cmd.job)
			3'd0, 3'd3: d_job = dx_q;
			3'd1, 3'd4: d_job = dy_q;
			default:    d_job = dz_q;
		endcase
		if (cmd.op == lwf_pkg::CMD_SQ_AB) begin
			unique case (cmd.cnt)
				6'd0:    sq_sel = a_q;
				6'd1:    sq_sel = b_q;
				default: sq_sel = '0;
			endcase
		end else begin
			unique case (cmd.cnt)
				6'd0:    sq_sel = dx_q;
				6'd1:    sq_sel = dy_q;
				6'd2:    sq_sel = dz_q;
				default: sq_sel = '0;
			endcase
		end
		k_job = (cmd.job < lwf_pkg::JOB_W'(lwf_pkg::AXES)) ? 32'(step_q) : 32'(cruise_q);
		if (cmd.op == lwf_pkg::CMD_SMUL) begin
			mul_a = lwf_pkg::mag33(d_job);
			mul_b = k_job;
		end else begin
			mul_a = lwf_pkg::mag33(sq_sel);
			mul_b = lwf_pkg::mag33(sq_sel);
		end
	end

	// one root bit per step
	assign t_rem = {srem_q[34:0], rad_q[67:66]};
	assign trial = {1'b0, root_q, 2'b01};
	assign take  = (t_rem >= trial);

	// one quotient bit per step
	assign shifted = {rem_q, numlo_q[31]};
	assign dtake   = (shifted >= {1'b0, den_q});

	assign snum = mul_q + 64'(dist_q >> 1);
	assign qsum = (cmd.job == '0) ? $signed({2'b00, r_q}) + 35'(a_q)
		: $signed({2'b00, r_q}) - 35'(a_q);
	assign qnum = 64'(qsum[33:0]) << lwf_pkg::QUAT_FRAC;

	assign q34     = $signed({2'b00, quo_q});
	assign sd      = d_job[32] ? -q34 : q34;
	assign rnd     = root_q[15:0] + 16'(srem_q > 37'(root_q));
	assign rnd_neg = -rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_q <= lwf_pkg::ACCEPT_RESET;
			look_q   <= lwf_pkg::LOOKAHEAD_RESET;
			cruise_q <= lwf_pkg::CRUISE_RESET;
			hold_q   <= lwf_pkg::HOLD_RESET;
			count_q  <= lwf_pkg::COUNT_RESET;
			idx_q    <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					lwf_pkg::REG_ACCEPT_RADIUS: accept_q <= cfg_data;
					lwf_pkg::REG_LOOKAHEAD:     look_q   <= cfg_data;
					lwf_pkg::REG_CRUISE_SPEED:  cruise_q <= cfg_data;
					lwf_pkg::REG_HOLD_AT_END:   hold_q   <= cfg_data[0];
					lwf_pkg::REG_WAYPOINT_CNT:  count_q  <= cfg_data[lwf_pkg::COUNT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.op == lwf_pkg::CMD_CLAMP) begin
				idx_q <= clamp_idx;
			end else if (cmd.op == lwf_pkg::CMD_CHECK) begin
				idx_q <= next_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == lwf_pkg::CMD_STORE_WP && slot_ok) begin
			mem_x[wr_addr] <= coord_x;
			mem_y[wr_addr] <= coord_y;
			mem_z[wr_addr] <= coord_z;
		end
		if (cmd.op == lwf_pkg::CMD_CLAMP || cmd.op == lwf_pkg::CMD_CHECK) begin
			wx_q <= mem_x[rd_addr];
			wy_q <= mem_y[rd_addr];
			wz_q <= mem_z[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			lwf_pkg::CMD_TAKE_POS: begin
				px_q <= coord_x;
				py_q <= coord_y;
				pz_q <= coord_z;
			end
			lwf_pkg::CMD_DIFF: begin
				dx_q  <= 33'(wx_q) - 33'(px_q);
				dy_q  <= 33'(wy_q) - 33'(py_q);
				dz_q  <= 33'(wz_q) - 33'(pz_q);
				acc_q <= '0;
				mul_q <= '0;
			end
			lwf_pkg::CMD_SQ_D, lwf_pkg::CMD_SQ_AB: begin
				acc_q <= acc_q + 66'(mul_q);
				mul_q <= mul_a * mul_b;
			end
			lwf_pkg::CMD_RT_ACC: begin
				rad_q  <= {2'b00, acc_q};
				root_q <= '0;
				srem_q <= '0;
			end
			lwf_pkg::CMD_RT_QUO: begin
				rad_q  <= 68'(quo_q);
				root_q <= '0;
				srem_q <= '0;
			end
			lwf_pkg::CMD_RT_STEP: begin
				rad_q  <= {rad_q[65:0], 2'b00};
				srem_q <= take ? t_rem - trial : t_rem;
				root_q <= {root_q[32:0], take};
			end
			lwf_pkg::CMD_CHECK: begin
				dist_q <= root_q[32:0];
				step_q <= (34'(look_q) < root_q) ? look_q : root_q[30:0];
			end
			lwf_pkg::CMD_ZERO: begin
				// target hit exactly: setpoint is the waypoint now followed
				sx_q <= 34'(wx_q);
				sy_q <= 34'(wy_q);
				sz_q <= 34'(wz_q);
				vx_q <= '0;
				vy_q <= '0;
				vz_q <= '0;
			end
			lwf_pkg::CMD_SMUL: begin
				mul_q <= mul_a * mul_b;
			end
			lwf_pkg::CMD_SDLOAD: begin
				rem_q   <= 33'(snum[63:32]);
				numlo_q <= snum[31:0];
				den_q   <= dist_q;
			end
			lwf_pkg::CMD_QDLOAD: begin
				rem_q   <= 33'(qnum[63:32]);
				numlo_q <= qnum[31:0];
				den_q   <= r_q;
			end
			lwf_pkg::CMD_DIV_STEP: begin
				rem_q   <= dtake ? 33'(shifted - {1'b0, den_q}) : shifted[32:0];
				numlo_q <= {numlo_q[30:0], 1'b0};
				quo_q   <= {quo_q[30:0], dtake};
			end
			lwf_pkg::CMD_SSTORE: begin
				unique case (cmd.job)
					3'd0:    sx_q <= 34'(px_q) + sd;
					3'd1:    sy_q <= 34'(py_q) + sd;
					3'd2:    sz_q <= 34'(pz_q) + sd;
					3'd3:    vx_q <= sd[31:0];
					3'd4:    vy_q <= sd[31:0];
					default: vz_q <= sd[31:0];
				endcase
			end
			lwf_pkg::CMD_AB: begin
				a_q   <= 33'(sx_q - 34'(px_q));
				b_q   <= 33'(sy_q - 34'(py_q));
				acc_q <= '0;
				mul_q <= '0;
			end
			lwf_pkg::CMD_RSTORE: begin
				r_q <= root_q[32:0];
			end
			lwf_pkg::CMD_QDEFAULT: begin
				qw_q <= lwf_pkg::Q_ONE;
				qz_q <= '0;
			end
			lwf_pkg::CMD_QSTORE: begin
				if (cmd.job == '0) qw_q <= rnd;
				else qz_q <= b_q[32] ? rnd_neg : rnd;
			end
			lwf_pkg::CMD_EMIT: begin
				osx_q  <= sx_q[31:0];
				osy_q  <= sy_q[31:0];
				osz_q  <= sz_q[31:0];
				ovx_q  <= vx_q;
				ovy_q  <= vy_q;
				ovz_q  <= vz_q;
				oqw_q  <= qw_q;
				oqz_q  <= qz_q;
				oidx_q <= lwf_pkg::IDX_PORT_W'(idx_q);
			end
			default: ;
		endcase
	end

	assign setpoint_x   = osx_q;
	assign setpoint_y   = osy_q;
	assign setpoint_z   = osz_q;
	assign velocity_x   = ovx_q;
	assign velocity_y   = ovy_q;
	assign velocity_z   = ovz_q;
	assign quat_w       = oqw_q;
	assign quat_z       = oqz_q;
	assign target_index = oidx_q;

endmodule
`default_nettype wire

// ===== design/lookahead_waypoint_follower.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lookahead_waypoint_follower
// Carrot-chasing 3D waypoint guidance: waypoint table, lookahead setpoint,
// velocity feedforward and heading quaternion in Q16.16 and Q1.14.
// ----------------------------------------------------------------------------
// A load beat writes one waypoint, and the block is ready again in the
// next cycle. Only one item is in work at a time. A tick beat keeps the
// input blocked until its result is emitted or dropped. A tick is shorter:
//   - when no horizontal offset is left (straight heading)
//   - when the result is suppressed at the last waypoint
//   - when the position sits on the target and the index advances
//   - when the position sits on a target that is kept
// A tick also waits while an earlier result still sits in the output
// register. The long steps are the shared one-bit-per-cycle square root
// (34 steps) and divider (32 steps). These run for the distance, six
// scalings, the horizontal radius and two quaternion parts. A finished
// result waits in the output register while the next beat is accepted.
module lookahead_waypoint_follower #(
	parameter int MAX_WAYPOINTS = lwf_pkg::MAX_WAYPOINTS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write,
	input  wire logic [lwf_pkg::REG_IDX_W-1:0]       cfg_index,
	input  wire logic [lwf_pkg::CFG_W-1:0]           cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                operation,
	input  wire logic [lwf_pkg::SLOT_W-1:0]          slot,
	input  wire logic signed [lwf_pkg::COORD_W-1:0]  coord_x,
	input  wire logic signed [lwf_pkg::COORD_W-1:0]  coord_y,
	input  wire logic signed [lwf_pkg::COORD_W-1:0]  coord_z,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [lwf_pkg::COORD_W-1:0]       setpoint_x,
	output logic signed [lwf_pkg::COORD_W-1:0]       setpoint_y,
	output logic signed [lwf_pkg::COORD_W-1:0]       setpoint_z,
	output logic signed [lwf_pkg::COORD_W-1:0]       velocity_x,
	output logic signed [lwf_pkg::COORD_W-1:0]       velocity_y,
	output logic signed [lwf_pkg::COORD_W-1:0]       velocity_z,
	output logic signed [lwf_pkg::QUAT_W-1:0]        quat_w,
	output logic signed [lwf_pkg::QUAT_W-1:0]        quat_z,
	output logic [lwf_pkg::IDX_PORT_W-1:0]           target_index
);

	lwf_pkg::cmd_t    cmd;
	lwf_pkg::status_t status;

	lwf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	lwf_dpath #(
		.MAX_WAYPOINTS (MAX_WAYPOINTS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.slot         (slot),
		.coord_x      (coord_x),
		.coord_y      (coord_y),
		.coord_z      (coord_z),
		.cmd          (cmd),
		.status       (status),
		.setpoint_x   (setpoint_x),
		.setpoint_y   (setpoint_y),
		.setpoint_z   (setpoint_z),
		.velocity_x   (velocity_x),
		.velocity_y   (velocity_y),
		.velocity_z   (velocity_z),
		.quat_w       (quat_w),
		.quat_z       (quat_z),
		.target_index (target_index)
	);

	// a tick beat keeps the block busy
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation |=> !in_ready)
		else $error("tick beat did not make the block busy");

	// a load beat finishes in its own cycle
	a_load_single: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !operation |=> in_ready)
		else $error("load beat held the block busy");

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.op == lwf_pkg::CMD_EMIT))
		else $error("result shown without an emit command");

	a_root_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == lwf_pkg::CMD_RT_STEP |-> !in_ready)
		else $error("input taken during a root step");

endmodule
`default_nettype wire
